// ===== rtl/tmcs_pkg.sv =====
// tmcs_pkg: shared constants, command and status types of the two-modulus
// congruence search. No dependencies; every other file but tmcs_div uses this package.
`default_nettype none

package tmcs_pkg;

  // default modulus width and the fixed result width
  localparam int MOD_BITS_DEF = 16;
  localparam int YEAR_BITS    = 32;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_START,
    OP_DIV_TAKE,
    OP_MUL,
    OP_SCAN_STEP,
    OP_OUT_HIT,
    OP_OUT_MISS
  } op_t;

  // which division the shared divider is working on
  typedef enum logic [2:0] {
    DIV_GCD,
    DIV_QUOT,
    DIV_RY,
    DIV_RX,
    DIV_MM
  } div_sel_t;

  typedef struct packed {
    op_t      op;
    div_sel_t div_sel;
  } cmd_t;

  typedef struct packed {
    logic zero_mod;   // m or n is zero
    logic q_zero;     // Euclid divisor has reached zero
    logic div_done;   // divider result valid this cycle
    logic over_limit; // scan value beyond lcm
    logic match;      // scan remainder equals wanted remainder
    logic out_busy;   // output register full and not being taken
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/tmcs_if.sv =====
// tmcs_in_if / tmcs_out_if: valid-ready channels of the congruence search.
// Depends on tmcs_pkg for default widths.
`default_nettype none

interface tmcs_in_if #(
  parameter int W = tmcs_pkg::MOD_BITS_DEF
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] modulus_m;
  logic [W-1:0] modulus_n;
  logic [W-1:0] residue_x;
  logic [W-1:0] residue_y;

  modport source (
    output valid, modulus_m, modulus_n, residue_x, residue_y,
    input  ready
  );
  modport sink (
    input  valid, modulus_m, modulus_n, residue_x, residue_y,
    output ready
  );
endinterface

interface tmcs_out_if ();
  logic                           valid;
  logic                           ready;
  logic [tmcs_pkg::YEAR_BITS-1:0] year;
  logic                           found;

  modport source (
    output valid, year, found,
    input  ready
  );
  modport sink (
    input  valid, year, found,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/tmcs_div.sv =====
// tmcs_div: restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameter; divisor must be non-zero.
`default_nettype none

module tmcs_div #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dsr_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [W:0] shifted;
  logic [W:0] diff;

  // one restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem_r, quo_r[W-1]};
    diff    = shifted - {1'b0, dsr_r};
    if (!diff[W]) begin
      rem_nxt = diff[W-1:0];
      quo_nxt = {quo_r[W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[W-1:0];
      quo_nxt = {quo_r[W-2:0], 1'b0};
    end
  end

  // control: count steps, pulse done after the last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ===== rtl/tmcs_dp.sv =====
// tmcs_dp: datapath of the congruence search: operand registers, Euclid state,
// lcm multiply, incremental remainder scan, output register.
// Depends on tmcs_pkg and tmcs_div.
`default_nettype none

module tmcs_dp #(
  parameter int W = tmcs_pkg::MOD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tmcs_pkg::cmd_t                 cmd,
  output tmcs_pkg::sts_t                 sts,
  input  logic [W-1:0]                   in_m,
  input  logic [W-1:0]                   in_n,
  input  logic [W-1:0]                   in_x,
  input  logic [W-1:0]                   in_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tmcs_pkg::YEAR_BITS-1:0] out_year,
  output logic                           out_found
);

  import tmcs_pkg::*;

  localparam int LW = 2 * W;     // lcm width
  localparam int VW = 2 * W + 1; // scan value width, room for one step past lcm

  logic [W-1:0]  m_r, n_r, x_r, y_r;
  logic [W-1:0]  p_r, q_r;
  logic [W-1:0]  quot_r;
  logic [LW-1:0] limit_r;
  logic [W-1:0]  ry_r, mm_r, r_r;
  logic [VW-1:0] v_r;
  logic [YEAR_BITS-1:0] year_r;
  logic          found_r;
  logic          out_valid_r;

  logic [W-1:0]  div_a, div_b, div_quo, div_rem;
  logic          div_start, div_done;
  logic [LW-1:0] prod;
  logic [W:0]    r_sum;
  logic [W-1:0]  r_nxt;

  // operand selection for the shared divider
  always_comb begin
    case (cmd.div_sel)
      DIV_GCD:  begin div_a = p_r; div_b = q_r; end
      DIV_QUOT: begin div_a = m_r; div_b = p_r; end
      DIV_RY:   begin div_a = y_r; div_b = n_r; end
      DIV_RX:   begin div_a = x_r; div_b = n_r; end
      DIV_MM:   begin div_a = m_r; div_b = n_r; end
      default:  begin div_a = m_r; div_b = n_r; end
    endcase
  end

  assign div_start = (cmd.op == OP_DIV_START);

  tmcs_div #(.W(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // lcm = (m / gcd) * n
  assign prod = quot_r * n_r;

  // next remainder mod n after adding m
  always_comb begin
    r_sum = {1'b0, r_r} + {1'b0, mm_r};
    if (r_sum >= {1'b0, n_r}) begin
      r_nxt = W'(r_sum - {1'b0, n_r});
    end else begin
      r_nxt = r_sum[W-1:0];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        m_r <= in_m;
        n_r <= in_n;
        x_r <= in_x;
        y_r <= in_y;
        p_r <= in_m;
        q_r <= in_n;
      end
      OP_DIV_TAKE: begin
        case (cmd.div_sel)
          DIV_GCD: begin
            p_r <= q_r;
            q_r <= div_rem;
          end
          DIV_QUOT: quot_r <= div_quo;
          DIV_RY:   ry_r <= div_rem;
          DIV_RX: begin
            r_r <= div_rem;
            v_r <= VW'(x_r);
          end
          DIV_MM:   mm_r <= div_rem;
          default:  mm_r <= div_rem;
        endcase
      end
      OP_MUL: limit_r <= prod;
      OP_SCAN_STEP: begin
        v_r <= v_r + VW'(m_r);
        r_r <= r_nxt;
      end
      OP_OUT_HIT: begin
        year_r  <= YEAR_BITS'(v_r);
        found_r <= 1'b1;
      end
      OP_OUT_MISS: begin
        year_r  <= '0;
        found_r <= 1'b0;
      end
      default: ;
    endcase
  end

  // output register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT_HIT || cmd.op == OP_OUT_MISS) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // status back to the controller
  assign sts.zero_mod   = (m_r == '0) || (n_r == '0);
  assign sts.q_zero     = (q_r == '0);
  assign sts.div_done   = div_done;
  assign sts.over_limit = (v_r > {1'b0, limit_r});
  assign sts.match      = (r_r == ry_r);
  assign sts.out_busy   = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_year  = year_r;
  assign out_found = found_r;

endmodule

`default_nettype wire

// ===== rtl/tmcs_ctrl.sv =====
// tmcs_ctrl: sequencer of the congruence search: Euclid loop, lcm, residue
// reductions, scan and result hand-off. Depends on tmcs_pkg.
`default_nettype none

module tmcs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tmcs_pkg::sts_t sts,
  output tmcs_pkg::cmd_t cmd
);

  import tmcs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LAUNCH,
    S_DIV_WAIT,
    S_GCD_TEST,
    S_MUL,
    S_SCAN,
    S_DONE
  } state_t;

  state_t   state_r, state_nxt;
  div_sel_t sel_r, sel_nxt;
  logic     hit_r, hit_nxt;

  // next state and datapath command
  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    hit_nxt     = hit_r;
    cmd.op      = OP_NONE;
    cmd.div_sel = sel_r;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.zero_mod) begin
          hit_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          cmd.op      = OP_DIV_START;
          cmd.div_sel = DIV_GCD;
          sel_nxt     = DIV_GCD;
          state_nxt   = S_DIV_WAIT;
        end
      end
      S_LAUNCH: begin
        cmd.op    = OP_DIV_START;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.op = OP_DIV_TAKE;
          case (sel_r)
            DIV_GCD:  state_nxt = S_GCD_TEST;
            DIV_QUOT: state_nxt = S_MUL;
            DIV_RY: begin
              sel_nxt   = DIV_RX;
              state_nxt = S_LAUNCH;
            end
            DIV_RX: begin
              sel_nxt   = DIV_MM;
              state_nxt = S_LAUNCH;
            end
            DIV_MM:   state_nxt = S_SCAN;
            default:  state_nxt = S_SCAN;
          endcase
        end
      end
      S_GCD_TEST: begin
        // Euclid ends when the divisor reaches zero; p then holds the gcd
        if (sts.q_zero) begin
          sel_nxt = DIV_QUOT;
        end
        state_nxt = S_LAUNCH;
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        sel_nxt   = DIV_RY;
        state_nxt = S_LAUNCH;
      end
      S_SCAN: begin
        if (sts.over_limit) begin
          hit_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else if (sts.match) begin
          hit_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.op = OP_SCAN_STEP;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.op    = hit_r ? OP_OUT_HIT : OP_OUT_MISS;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= DIV_GCD;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      hit_r   <= hit_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/two_modulus_congruence_search.sv =====
// Channel  Dir  Payload                                            Handshake
// in_ch    in   modulus_m, modulus_n, residue_x, residue_y (W bits) valid/ready
// out_ch   out  year (32 bits), found (1 bit)                       valid/ready
//
// One item at a time. The scan takes at most n/gcd(m,n) + 1 steps; a zero
// modulus skips the Euclid loop and the scan and gives found = 0. The shared
// bit-serial divider serves the Euclid loop, the lcm quotient and the residue
// reductions.
// Reset (rst_n low, synchronous) empties the block; no clearing pass is needed.
// The result sits in an output register, so a stalled output holds only the
// next result's hand-off, not the start of the next item.
// Depends on tmcs_pkg, tmcs_if, tmcs_ctrl, tmcs_dp and tmcs_div.
`default_nettype none

module two_modulus_congruence_search #(
  parameter int MOD_BITS = tmcs_pkg::MOD_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  tmcs_in_if.sink    in_ch,
  tmcs_out_if.source out_ch
);

  import tmcs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tmcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tmcs_dp #(.W(MOD_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_m      (in_ch.modulus_m),
    .in_n      (in_ch.modulus_n),
    .in_x      (in_ch.residue_x),
    .in_y      (in_ch.residue_y),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_year  (out_ch.year),
    .out_found (out_ch.found)
  );

endmodule

`default_nettype wire
